[rtl/icr_pkg.sv]
// ----------------------------------------------------------------------------
// Clock recovery package
// Types, constants and fixed-point helpers shared by the recovery block.
// ----------------------------------------------------------------------------
package icr_pkg;

   typedef struct packed {
      logic        opcode;
      logic [31:0] event_time_us;
      logic [7:0]  completed_count;
      logic [31:0] query_stream_time;
   } req_type;

   typedef struct packed {
      logic [31:0]        converted_local_time;
      logic [31:0]        ref_local_time;
      logic [31:0]        ref_stream_time;
      logic signed [31:0] drift_ppm_q16;
      logic               reference_updated;
      logic [1:0]         run_state;
   } rsp_type;

   localparam int unsigned WINDOW_US_DEFAULT = 1000000;

   localparam int          CSR_AW         = 3;
   localparam logic        REG_INTERVAL   = 1'b0;
   localparam logic [16:0] INTERVAL_RESET = 17'd10000;

   localparam logic OPCODE_EVENT   = 1'b0;
   localparam logic OPCODE_CONVERT = 1'b1;

   localparam logic [1:0] PHASE_RESET   = 2'd0;
   localparam logic [1:0] PHASE_WARMUP  = 2'd1;
   localparam logic [1:0] PHASE_RUNNING = 2'd2;

   localparam logic signed [31:0] COEF_A1 = -32'sd2068009541;
   localparam logic signed [31:0] COEF_A2 = 32'sd997105741;
   localparam logic signed [31:0] COEF_B0 = 32'sd709506;
   localparam logic signed [31:0] COEF_B1 = 32'sd1419012;

   // The divisor 10^6 splits into 2^6 and 15625; CONV_RECIP is floor(2^45 / 15625).
   localparam logic [31:0] CMIN_RESET = 32'h7FFF_FFFF;
   localparam logic [63:0] CONV_HALF  = 64'd32768000000;
   localparam logic [31:0] CONV_DIV   = 32'd15625;
   localparam logic [31:0] CONV_RECIP = 32'd2251799813;
   localparam int          QUOT_BITS  = 27;

   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? S64_MIN : S64_MAX;
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? S64_MIN : S64_MAX;
      end
      return s[63:0];
   endfunction

   function automatic logic [31:0] to_q16(input logic signed [63:0] x);
      logic [63:0] mag;
      logic [64:0] sum;
      logic [48:0] m;
      mag = x[63] ? (64'd0 - x) : x;
      sum = {1'b0, mag} + 65'd32768;
      m   = sum[64:16];
      if (x[63]) begin
         if (m > 49'h0_8000_0000) begin
            m = 49'h0_8000_0000;
         end
         return 32'd0 - m[31:0];
      end
      if (m > 49'h0_7FFF_FFFF) begin
         m = 49'h0_7FFF_FFFF;
      end
      return m[31:0];
   endfunction

endpackage

[rtl/icr_front.sv]
// ----------------------------------------------------------------------------
// Clock recovery front
// Accepts request transfers into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module icr_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  icr_pkg::req_type req_data,
   output logic             q_valid,
   output icr_pkg::req_type q_data,
   input  logic             q_pop
);

   icr_pkg::req_type slot_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             push;
   logic             pop;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_data    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

[rtl/icr_back.sv]
// ----------------------------------------------------------------------------
// Clock recovery back end
// Sequencer with one shared multiplier: event tracking, drift filter,
// stream correction, stream-to-local conversion and the result register.
// ----------------------------------------------------------------------------
module icr_back #(
   parameter int unsigned WINDOW_US = icr_pkg::WINDOW_US_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  icr_pkg::req_type q_data,
   output logic             q_pop,
   input  logic [16:0]      interval_len,
   output logic             rsp_valid,
   output icr_pkg::rsp_type rsp_data,
   input  logic             rsp_stall
);

   typedef enum logic [4:0] {
      S_IDLE, S_EV_STEP, S_EV_ADV, S_EV_WIN, S_EV_ALIGN, S_EV_DRIFT,
      S_F_LO, S_F_HI, S_F_FIN, S_F_ACC, S_EV_ERR, S_EV_CORR, S_EV_PUB,
      S_CV_SUB, S_CV_MUL, S_CV_RND, S_CV_REC, S_CV_QEST, S_CV_BACK, S_CV_FIX,
      S_CV_FIN, S_EMIT
   } state_type;

   localparam logic [31:0] WINDOW = 32'(WINDOW_US);
   localparam int QUOT_W = icr_pkg::QUOT_BITS;

   state_type          state_ff;
   icr_pkg::req_type   req_ff;
   logic [1:0]         phase_ff;
   logic [31:0]        start_ff, local_ff, stream_ff, wstart_ff;
   logic [31:0]        pmin_ff, cmin_ff, drift_ff;
   logic signed [63:0] fout_ff, s0_ff, s1_ff, mb0_ff, tmp_ff, r_ff;
   logic [31:0]        pub_local_ff, pub_stream_ff, dq16_ff;
   logic [1:0]         fstep_ff;
   logic [63:0]        prod_ff, lo_ff;
   logic [31:0]        err_ff;
   logic signed [32:0] trunc_ff;
   logic [31:0]        sdt_ff;
   logic               neg_ff;
   logic [40:0]        rem_ff;
   logic [QUOT_W-1:0]  quot_ff;
   logic [31:0]        conv_ff;
   logic               upd_ff;
   logic               rsp_valid_ff;
   icr_pkg::rsp_type   rsp_ff;

   logic [31:0]        mul_a, mul_b;
   logic signed [63:0] src_x;
   logic [63:0]        xmag;
   logic signed [31:0] coef;
   logic [31:0]        cmag;
   logic               mneg;
   logic [95:0]        pfull;
   logic [65:0]        mround;
   logic signed [63:0] mres;
   logic [31:0]        dt;
   logic [31:0]        cmin_new;
   logic [39:0]        tm;
   logic signed [34:0] corr;
   logic [63:0]        ysum;
   logic [40:0]        rfix;
   logic [31:0]        extra;
   logic               slot_free;
   logic               emit;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign emit      = (state_ff == S_EMIT) && slot_free;
   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      src_x = (fstep_ff[1] == 1'b0) ? $signed({drift_ff, 32'd0}) : fout_ff;
      xmag  = src_x[63] ? (64'd0 - src_x) : src_x;
      unique case (fstep_ff)
         2'd0:    coef = icr_pkg::COEF_B0;
         2'd1:    coef = icr_pkg::COEF_B1;
         2'd2:    coef = icr_pkg::COEF_A1;
         default: coef = icr_pkg::COEF_A2;
      endcase
      cmag   = coef[31] ? (32'd0 - coef) : coef;
      mneg   = src_x[63] ^ coef[31];
      pfull  = {prod_ff, 32'd0} + {32'd0, lo_ff} + 96'd536870912;
      mround = pfull[95:30];
      if (mneg) begin
         mres = (mround > 66'h8000_0000_0000_0000) ? icr_pkg::S64_MIN
                                                   : (64'd0 - mround[63:0]);
      end else begin
         mres = (mround > 66'h7FFF_FFFF_FFFF_FFFF) ? icr_pkg::S64_MAX
                                                   : mround[63:0];
      end
   end

   always_comb begin
      dt       = req_ff.event_time_us - local_ff;
      cmin_new = ($signed(dt) < $signed(cmin_ff)) ? dt : cmin_ff;
      tm       = fout_ff[63] ? 40'((64'd0 - fout_ff) >> 24) : 40'(fout_ff >> 24);
      corr     = 35'(trunc_ff) - 35'($signed(err_ff)) + 35'sd128;
      ysum     = prod_ff + icr_pkg::CONV_HALF;
      rfix     = rem_ff - prod_ff[40:0];
      extra    = neg_ff ? (32'd0 - 32'(quot_ff)) : 32'(quot_ff);
   end

   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      unique case (state_ff)
         S_EV_STEP: begin
            mul_a = 32'(req_ff.completed_count);
            mul_b = 32'(interval_len);
         end
         S_F_LO: begin
            mul_a = xmag[31:0];
            mul_b = cmag;
         end
         S_F_HI: begin
            mul_a = xmag[63:32];
            mul_b = cmag;
         end
         S_CV_MUL: begin
            mul_a = sdt_ff[31] ? (32'd0 - sdt_ff) : sdt_ff;
            mul_b = dq16_ff[31] ? (32'd0 - dq16_ff) : dq16_ff;
         end
         S_CV_REC: begin
            mul_a = rem_ff[40:9];
            mul_b = icr_pkg::CONV_RECIP;
         end
         S_CV_BACK: begin
            mul_a = 32'(quot_ff);
            mul_b = icr_pkg::CONV_DIV;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= icr_pkg::PHASE_RESET;
         start_ff      <= 32'd0;
         local_ff      <= 32'd0;
         stream_ff     <= 32'd0;
         wstart_ff     <= 32'd0;
         pmin_ff       <= 32'd0;
         cmin_ff       <= icr_pkg::CMIN_RESET;
         fout_ff       <= 64'sd0;
         s0_ff         <= 64'sd0;
         s1_ff         <= 64'sd0;
         pub_local_ff  <= 32'd0;
         pub_stream_ff <= 32'd0;
         dq16_ff       <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  req_ff   <= q_data;
                  state_ff <= (q_data.opcode == icr_pkg::OPCODE_CONVERT) ? S_CV_SUB
                                                                         : S_EV_STEP;
               end
            end
            S_EV_STEP: begin
               if (phase_ff == icr_pkg::PHASE_RESET) begin
                  start_ff  <= req_ff.event_time_us;
                  local_ff  <= req_ff.event_time_us;
                  stream_ff <= req_ff.event_time_us;
                  wstart_ff <= req_ff.event_time_us;
                  cmin_ff   <= icr_pkg::CMIN_RESET;
                  phase_ff  <= icr_pkg::PHASE_WARMUP;
               end
               state_ff <= S_EV_ADV;
            end
            S_EV_ADV: begin
               local_ff  <= local_ff + prod_ff[31:0];
               stream_ff <= stream_ff + prod_ff[31:0];
               state_ff  <= S_EV_WIN;
            end
            S_EV_WIN: begin
               cmin_ff <= cmin_new;
               conv_ff <= 32'd0;
               upd_ff  <= 1'b0;
               if ((local_ff - wstart_ff) < WINDOW) begin
                  state_ff <= S_EMIT;
               end else begin
                  wstart_ff <= wstart_ff + WINDOW;
                  state_ff  <= (phase_ff == icr_pkg::PHASE_WARMUP) ? S_EV_ALIGN
                                                                   : S_EV_DRIFT;
               end
            end
            S_EV_ALIGN: begin
               wstart_ff <= wstart_ff + cmin_ff;
               local_ff  <= local_ff + cmin_ff;
               stream_ff <= stream_ff + cmin_ff;
               pmin_ff   <= 32'd0;
               cmin_ff   <= icr_pkg::CMIN_RESET;
               phase_ff  <= icr_pkg::PHASE_RUNNING;
               state_ff  <= S_EMIT;
            end
            S_EV_DRIFT: begin
               drift_ff <= cmin_ff - pmin_ff;
               pmin_ff  <= cmin_ff;
               cmin_ff  <= icr_pkg::CMIN_RESET;
               fstep_ff <= 2'd0;
               state_ff <= S_F_LO;
            end
            S_F_LO: begin
               state_ff <= S_F_HI;
            end
            S_F_HI: begin
               lo_ff    <= prod_ff;
               state_ff <= S_F_FIN;
            end
            S_F_FIN: begin
               r_ff     <= mres;
               state_ff <= S_F_ACC;
            end
            S_F_ACC: begin
               unique case (fstep_ff)
                  2'd0: begin
                     mb0_ff  <= r_ff;
                     fout_ff <= icr_pkg::sat_add(r_ff, s0_ff);
                  end
                  2'd1: tmp_ff <= icr_pkg::sat_add(s1_ff, r_ff);
                  2'd2: s0_ff  <= icr_pkg::sat_sub(tmp_ff, r_ff);
                  default: s1_ff <= icr_pkg::sat_sub(mb0_ff, r_ff);
               endcase
               fstep_ff <= fstep_ff + 2'd1;
               state_ff <= (fstep_ff == 2'd3) ? S_EV_ERR : S_F_LO;
            end
            S_EV_ERR: begin
               err_ff <= stream_ff - (local_ff + pmin_ff);
               if (fout_ff[63]) begin
                  trunc_ff <= (tm > 40'h80_0000_0000 >> 8) ? -33'sd2147483648
                                                           : -$signed({1'b0, tm[31:0]});
               end else begin
                  trunc_ff <= (tm > 40'h00_7FFF_FFFF) ? 33'sd2147483647
                                                      : $signed({1'b0, tm[31:0]});
               end
               state_ff <= S_EV_CORR;
            end
            S_EV_CORR: begin
               stream_ff <= stream_ff + 32'(corr >>> 8);
               state_ff  <= S_EV_PUB;
            end
            S_EV_PUB: begin
               pub_local_ff  <= local_ff - start_ff;
               pub_stream_ff <= stream_ff - start_ff;
               dq16_ff       <= icr_pkg::to_q16(fout_ff);
               upd_ff        <= 1'b1;
               state_ff      <= S_EMIT;
            end
            S_CV_SUB: begin
               sdt_ff   <= req_ff.query_stream_time - pub_stream_ff;
               state_ff <= S_CV_MUL;
            end
            S_CV_MUL: begin
               neg_ff   <= sdt_ff[31] ^ dq16_ff[31];
               state_ff <= S_CV_RND;
            end
            S_CV_RND: begin
               rem_ff   <= ysum[62:22];
               state_ff <= S_CV_REC;
            end
            S_CV_REC: begin
               state_ff <= S_CV_QEST;
            end
            S_CV_QEST: begin
               quot_ff  <= prod_ff[36 +: QUOT_W];
               state_ff <= S_CV_BACK;
            end
            S_CV_BACK: begin
               state_ff <= S_CV_FIX;
            end
            S_CV_FIX: begin
               if (rfix >= 41'(icr_pkg::CONV_DIV)) begin
                  quot_ff <= quot_ff + QUOT_W'(1);
               end
               state_ff <= S_CV_FIN;
            end
            S_CV_FIN: begin
               conv_ff  <= pub_local_ff + sdt_ff + extra;
               upd_ff   <= 1'b0;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (slot_free) begin
                  rsp_ff.converted_local_time <= conv_ff;
                  rsp_ff.ref_local_time       <= pub_local_ff;
                  rsp_ff.ref_stream_time      <= pub_stream_ff;
                  rsp_ff.drift_ppm_q16        <= $signed(dq16_ff);
                  rsp_ff.reference_updated    <= upd_ff;
                  rsp_ff.run_state            <= phase_ff;
                  state_ff                    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_upd_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.reference_updated |->
         rsp_ff.run_state == icr_pkg::PHASE_RUNNING)
      else $error("reference update reported outside running phase");

   a_upd_no_conv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.reference_updated |-> rsp_ff.converted_local_time == 32'd0)
      else $error("event result carries a converted time");

   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && rsp_valid_ff && rsp_stall |=> state_ff == S_EMIT)
      else $error("result left the sequencer while the output was stalled");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != S_IDLE)
      else $error("queue popped without starting work");

endmodule

[rtl/iso_clock_recovery.sv]
// ----------------------------------------------------------------------------
// Isochronous stream clock recovery
// Tracks window minimum deviation, filters drift and publishes a reference;
// converts stream time to local time on request.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                          Transfer when
//  req       in         req_valid, req_stall, req_data   valid && !stall
//  rsp       out        rsp_valid, rsp_stall, rsp_data   valid && !stall
//  csr       in/out     csr_psel .. csr_prdata           psel && penable && pwrite
//
// A running window close makes four sequential passes of two products
// through the shared 32x32 multiplier. A conversion divides by 10^6 with
// a reciprocal multiplication and one correction step.
// Reset is synchronous; no clearing pass is needed after it.
// A two-entry input queue keeps accepting, until full, while a result waits on rsp_stall.
// ----------------------------------------------------------------------------
module iso_clock_recovery #(
   parameter int unsigned WINDOW_US = icr_pkg::WINDOW_US_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  icr_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output icr_pkg::rsp_type           rsp_data,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [icr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic             q_valid;
   icr_pkg::req_type q_data;
   logic             q_pop;
   logic [16:0]      interval_ff;
   logic             reg_hit;

   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[2] == icr_pkg::REG_INTERVAL);
   assign csr_prdata = reg_hit ? {15'd0, interval_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= icr_pkg::INTERVAL_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         interval_ff <= csr_pwdata[16:0];
      end
   end

   icr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   icr_back #(
      .WINDOW_US (WINDOW_US)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_data),
      .q_pop        (q_pop),
      .interval_len (interval_ff),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .rsp_stall    (rsp_stall)
   );

endmodule
